// ===== hdl/rdsgd_pkg.sv =====
// rdsgd_pkg: shared types, codes and constants of the rds group decoder
// no dependencies; imported by every module of the decoder
package rdsgd_pkg;

  localparam int unsigned RtDepth  = 64;
  localparam int unsigned RtAw     = $clog2(RtDepth);
  localparam logic [7:0]  CharSpace = 8'h20;
  localparam logic [7:0]  CharCr    = 8'h0D;
  localparam logic [7:0]  CharLast  = 8'd126;
  localparam logic [31:0] PsMergeMark = 32'h4444_4444;
  localparam logic [31:0] PsQualInit  = 32'hFFFF_FFFF;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_PROC  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // group types of interest
  localparam logic [3:0] GroupPs = 4'd0;
  localparam logic [3:0] GroupRt = 4'd2;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RTWR  = 7'b0000100,
    S_PAD   = 7'b0001000,
    S_BLANK = 7'b0010000,
    S_RD    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  // command to the station name unit
  typedef struct packed {
    logic        en;
    logic        clr;
    logic [7:0]  blo;
    logic [15:0] d;
    logic [1:0]  err_b;
    logic [1:0]  err_d;
  } ps_cmd_t;

  // printable filter: control and high bytes become space, zero is kept
  function automatic logic [7:0] clean_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c != 8'd0 && c < CharSpace) || c > CharLast) r = CharSpace;
    return r;
  endfunction

endpackage

// ===== hdl/rdsgd_if.sv =====
// rdsgd_if: valid/ready channel interfaces of the rds group decoder
// no dependencies
interface rdsgd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] rds_status;
  logic [15:0] block_a;
  logic [15:0] block_b;
  logic [15:0] block_c;
  logic [15:0] block_d;
  logic [15:0] block_errors;
  logic        read_target;
  logic [5:0]  read_index;

  modport source(output valid, func, rds_status, block_a, block_b, block_c, block_d,
                 block_errors, read_target, read_index, input ready);
  modport sink(input valid, func, rds_status, block_a, block_b, block_c, block_d,
               block_errors, read_target, read_index, output ready);
endinterface

interface rdsgd_out_if;
  logic        valid;
  logic        ready;
  logic        data_taken;
  logic        sync_seen;
  logic [15:0] pi_code;
  logic        pi_known;
  logic [4:0]  pty_code;
  logic        pty_known;
  logic        ps_done;
  logic        text_new;
  logic [7:0]  char_out;

  modport source(output valid, data_taken, sync_seen, pi_code, pi_known, pty_code,
                 pty_known, ps_done, text_new, char_out, input ready);
  modport sink(input valid, data_taken, sync_seen, pi_code, pi_known, pty_code,
               pty_known, ps_done, text_new, char_out, output ready);
endinterface

// ===== hdl/rdsgd_rt_mem.sv =====
// rdsgd_rt_mem: radio text character memory, one write and one read port
// depends on rdsgd_pkg
module rdsgd_rt_mem
  import rdsgd_pkg::*;
#(
  parameter int unsigned Depth = RtDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rdsgd_ps.sv =====
// rdsgd_ps: station name assembly in two halves with per-slot quality bits
// depends on rdsgd_pkg
module rdsgd_ps
  import rdsgd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ps_cmd_t    cmd_i,
  input  logic [2:0] rd_idx_i,
  output logic [7:0] rd_char_o,
  output logic       done_o
);

  logic [7:0]  work_q [16];
  logic [7:0]  work_d [16];
  logic [7:0]  shown_q [8];
  logic [7:0]  shown_d [8];
  logic [7:0]  filled_q, filled_d;
  logic [31:0] qual_q, qual_d;
  logic        half_q, half_d;
  logic [1:0]  lseg_q, lseg_d;

  // merge and commit logic for one type 0 group
  always_comb begin
    logic [1:0] seg;
    logic [1:0] err_ps;
    logic       half1;
    logic [4:0] bpos;
    logic [2:0] fpos;
    logic       upd;
    logic       same;
    logic       commit;
    logic       zero_seen;
    logic [7:0] c;
    seg    = cmd_i.blo[1:0];
    err_ps = (cmd_i.err_b > cmd_i.err_d) ? cmd_i.err_b : cmd_i.err_d;
    work_d   = work_q;
    shown_d  = shown_q;
    filled_d = filled_q;
    qual_d   = qual_q;
    half_d   = half_q;
    lseg_d   = lseg_q;
    done_o   = 1'b0;
    half1    = half_q;
    bpos     = '0;
    fpos     = '0;
    upd      = 1'b0;
    same     = 1'b1;
    commit   = 1'b0;
    zero_seen = 1'b0;
    c        = '0;
    if (cmd_i.clr) begin
      for (int i = 0; i < 8; i++) shown_d[i] = CharSpace;
      qual_d   = PsQualInit;
      filled_d = '0;
    end else if (cmd_i.en) begin
      // segment wrap switches halves
      if (seg < lseg_q) begin
        qual_d = qual_q | PsMergeMark;
        half1  = ~half_q;
      end
      half_d = half1;
      lseg_d = seg;
      bpos   = 5'd31 - {half1, seg, 2'b00};
      fpos   = 3'd7 - {half1, seg};
      upd    = !filled_q[fpos] || err_ps <= 2'd1 || (qual_d[bpos - 5'd2] && !qual_d[bpos]);
      if (upd) begin
        filled_d[fpos] = 1'b1;
        qual_d[bpos]          = 1'b0;
        qual_d[bpos - 5'd1]   = 1'b0;
        if (err_ps <= 2'd1) begin
          qual_d[bpos - 5'd2] = 1'b0;
          if (err_ps == 2'd1) qual_d[bpos - 5'd3] = 1'b1;
        end
        if (err_ps == 2'd0 || err_ps == 2'd2) qual_d[bpos - 5'd3] = 1'b0;
        if (cmd_i.d[15:8] != 8'd0) work_d[{half1, seg, 1'b0}] = cmd_i.d[15:8];
        if (cmd_i.d[7:0] != 8'd0)  work_d[{half1, seg, 1'b1}] = cmd_i.d[7:0];
      end
      // commit when both halves agree or the current half is clean
      for (int i = 0; i < 8; i++) begin
        if (work_d[i] != work_d[i + 8]) same = 1'b0;
      end
      commit = (filled_d == 8'hFF && same) ||
               (half1 ? (qual_d[15:0] == 16'd0) : (qual_d[31:16] == 16'd0));
      if (commit) begin
        for (int i = 0; i < 8; i++) begin
          c = work_d[{half1, 3'(i)}];
          if (c == 8'd0) zero_seen = 1'b1;
          shown_d[i] = zero_seen ? 8'd0 : clean_char(c);
        end
        filled_d = '0;
        qual_d   = PsQualInit;
        done_o   = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) work_q[i] <= '0;
      for (int i = 0; i < 8; i++) shown_q[i] <= CharSpace;
      filled_q <= '0;
      qual_q   <= PsQualInit;
      half_q   <= 1'b0;
      lseg_q   <= '0;
    end else begin
      work_q   <= work_d;
      shown_q  <= shown_d;
      filled_q <= filled_d;
      qual_q   <= qual_d;
      half_q   <= half_d;
      lseg_q   <= lseg_d;
    end
  end

  assign rd_char_o = shown_q[rd_idx_i];

endmodule

// ===== hdl/rds_group_decoder.sv =====
// rds_group_decoder: top level, item sequencer and radio text write walker
// depends on rdsgd_pkg, rdsgd_if, rdsgd_ps, rdsgd_rt_mem
//
//  channel  | dir | handshake   | word
//  in_i     | in  | valid/ready | func, status, blocks a-d, errors, read target/index
//  out_o    | out | valid/ready | flags, pi, pty, char_out
//
// a text read waits for the registered memory data; a text group writes its bytes,
//   then pads from a carriage return, then blanks the text on an a/b toggle; clear
//   blanks it too. the walks go through the single write port of the text memory
// reset: after reset a pass fills the text memory with spaces, not ready meanwhile
// stalls: one item at a time; a finished word waits in the output register while
//   the next item is taken, the next result waits for that register to drain
module rds_group_decoder
  import rdsgd_pkg::*;
#(
  parameter int unsigned Depth = RtDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdsgd_in_if.sink    in_i,
  rdsgd_out_if.source out_o
);

  localparam int unsigned Aw = $clog2(Depth);
  localparam logic [Aw-1:0] AddrLast = Aw'(Depth - 1);

  state_e        state_q, state_d;
  logic [Aw-1:0] cnt_q, cnt_d;

  // decoded values
  logic [15:0] pi_q, pi_d;
  logic        piv_q, piv_d;
  logic [4:0]  pty_q, pty_d;
  logic        ptyv_q, ptyv_d;
  logic        abf_q, abf_d;
  logic        newt_q, newt_d;

  // per-item result bits
  logic        taken_q, taken_d;
  logic        sync_q, sync_d;
  logic        psd_q, psd_d;
  logic [7:0]  ch_q, ch_d;

  // latched text group
  logic [15:0] rtc_q, rtc_d, rtd_q, rtd_d;
  logic [3:0]  rta_q, rta_d;
  logic        rtb_q, rtb_d;
  logic        cr_q, cr_d;
  logic [Aw-1:0] len_q, len_d;
  logic        tog_q, tog_d;

  // output register
  logic        ovld_q;
  logic        taken_o_q, sync_o_q, piv_o_q, ptyv_o_q, psd_o_q, newt_o_q;
  logic [15:0] pi_o_q;
  logic [4:0]  pty_o_q;
  logic [7:0]  ch_o_q;

  ps_cmd_t     ps_cmd;
  logic [7:0]  ps_char;
  logic        ps_done;

  logic          mem_we, mem_re;
  logic [Aw-1:0] mem_waddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic accept, out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !ovld_q || out_o.ready;

  // sequencer and item decode
  always_comb begin
    logic [7:0] bytes [4];
    logic [1:0] err_b;
    bytes = '{in_i.block_c[15:8], in_i.block_c[7:0], in_i.block_d[15:8], in_i.block_d[7:0]};
    err_b   = in_i.block_errors[13:12];
    state_d = state_q;
    cnt_d   = cnt_q;
    pi_d = pi_q; piv_d = piv_q; pty_d = pty_q; ptyv_d = ptyv_q;
    abf_d = abf_q; newt_d = newt_q;
    taken_d = taken_q; sync_d = sync_q; psd_d = psd_q; ch_d = ch_q;
    rtc_d = rtc_q; rtd_d = rtd_q; rta_d = rta_q; rtb_d = rtb_q;
    cr_d = cr_q; len_d = len_q; tog_d = tog_q;
    ps_cmd = '0;
    ps_cmd.blo   = in_i.block_b[7:0];
    ps_cmd.d     = in_i.block_d;
    ps_cmd.err_b = err_b;
    ps_cmd.err_d = in_i.block_errors[9:8];
    mem_re = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AddrLast) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          taken_d = 1'b0; sync_d = 1'b0; psd_d = 1'b0; ch_d = '0;
          state_d = S_DONE;
          unique case (func_e'(in_i.func))
            FUNC_PROC: begin
              sync_d = in_i.rds_status[9];
              if (in_i.rds_status[15]) begin
                taken_d = 1'b1;
                if (err_b <= 2'd1) begin
                  pty_d  = in_i.block_b[9:5];
                  ptyv_d = 1'b1;
                end
                if (in_i.block_errors[15:14] == 2'd0) begin
                  pi_d  = in_i.block_a;
                  piv_d = 1'b1;
                end
                if (in_i.block_b[15:12] == GroupPs) begin
                  ps_cmd.en = 1'b1;
                  psd_d     = ps_done;
                end else if (in_i.block_b[15:12] == GroupRt && err_b == 2'd0) begin
                  rtc_d = in_i.block_c;
                  rtd_d = in_i.block_d;
                  rta_d = in_i.block_b[3:0];
                  rtb_d = in_i.rds_status[12];
                  tog_d = in_i.block_b[4] != abf_q;
                  newt_d = in_i.block_b[4] != abf_q;
                  abf_d  = in_i.block_b[4];
                  cr_d  = 1'b0;
                  len_d = '0;
                  // last carriage return of a version a group starts the padding
                  for (int i = 0; i < 4; i++) begin
                    if (!in_i.rds_status[12] && bytes[i] == CharCr) begin
                      cr_d  = 1'b1;
                      len_d = {in_i.block_b[3:0], 2'(i)};
                    end
                  end
                  cnt_d   = '0;
                  state_d = S_RTWR;
                end
              end
            end
            FUNC_READ: begin
              if (in_i.read_target) begin
                mem_re  = 1'b1;
                state_d = S_RD;
              end else begin
                ch_d = (in_i.read_index < 6'd8) ? ps_char : 8'd0;
              end
            end
            FUNC_CLEAR: begin
              pi_d = '0; piv_d = 1'b0; pty_d = '0; ptyv_d = 1'b0;
              ps_cmd.clr = 1'b1;
              cnt_d   = '0;
              state_d = S_BLANK;
            end
            default: ;
          endcase
        end
      end
      S_RTWR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          if (cr_q) begin
            cnt_d   = len_q;
            state_d = S_PAD;
          end else if (tog_q) begin
            cnt_d   = '0;
            state_d = S_BLANK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PAD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AddrLast) begin
          cnt_d   = '0;
          state_d = tog_q ? S_BLANK : S_DONE;
        end
      end
      S_BLANK: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AddrLast) state_d = S_DONE;
      end
      S_RD: begin
        ch_d    = mem_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // text memory write port: char writes, padding and blanking walks
  always_comb begin
    logic [7:0] wbyte;
    wbyte     = '0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = CharSpace;
    if (state_q == S_INIT || state_q == S_PAD || state_q == S_BLANK) begin
      mem_we = 1'b1;
    end else if (state_q == S_RTWR) begin
      if (!rtb_q) begin
        unique case (cnt_q[1:0])
          2'd0:    wbyte = rtc_q[15:8];
          2'd1:    wbyte = rtc_q[7:0];
          2'd2:    wbyte = rtd_q[15:8];
          default: wbyte = rtd_q[7:0];
        endcase
        mem_waddr = Aw'({rta_q, cnt_q[1:0]});
        mem_we    = wbyte != CharCr;
      end else begin
        wbyte     = cnt_q[0] ? rtd_q[7:0] : rtd_q[15:8];
        mem_waddr = Aw'({rta_q[2:0], cnt_q[0]});
        mem_we    = !cnt_q[1] && !rta_q[3] && wbyte != 8'd0;
      end
      mem_wdata = clean_char(wbyte);
    end
  end

  // control and value registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      pi_q <= '0; piv_q <= 1'b0; pty_q <= '0; ptyv_q <= 1'b0;
      abf_q <= 1'b0; newt_q <= 1'b0;
      taken_q <= 1'b0; sync_q <= 1'b0; psd_q <= 1'b0; ch_q <= '0;
      cr_q <= 1'b0; tog_q <= 1'b0; rtb_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pi_q <= pi_d; piv_q <= piv_d; pty_q <= pty_d; ptyv_q <= ptyv_d;
      abf_q <= abf_d; newt_q <= newt_d;
      taken_q <= taken_d; sync_q <= sync_d; psd_q <= psd_d; ch_q <= ch_d;
      cr_q <= cr_d; tog_q <= tog_d; rtb_q <= rtb_d;
    end
  end

  // text group payload
  always_ff @(posedge clk_i) begin
    rtc_q <= rtc_d;
    rtd_q <= rtd_d;
    rta_q <= rta_d;
    len_q <= len_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      ovld_q <= 1'b1;
    end else if (out_o.ready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      taken_o_q <= taken_q;
      sync_o_q  <= sync_q;
      pi_o_q    <= pi_q;
      piv_o_q   <= piv_q;
      pty_o_q   <= pty_q;
      ptyv_o_q  <= ptyv_q;
      psd_o_q   <= psd_q;
      newt_o_q  <= newt_q;
      ch_o_q    <= ch_q;
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.data_taken = taken_o_q;
  assign out_o.sync_seen  = sync_o_q;
  assign out_o.pi_code    = pi_o_q;
  assign out_o.pi_known   = piv_o_q;
  assign out_o.pty_code   = pty_o_q;
  assign out_o.pty_known  = ptyv_o_q;
  assign out_o.ps_done    = psd_o_q;
  assign out_o.text_new   = newt_o_q;
  assign out_o.char_out   = ch_o_q;

  rdsgd_ps u_ps (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ps_cmd),
    .rd_idx_i (in_i.read_index[2:0]),
    .rd_char_o(ps_char),
    .done_o   (ps_done)
  );

  rdsgd_rt_mem #(
    .Depth(Depth)
  ) u_rt_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(Aw'(in_i.read_index)),
    .rdata_o(mem_rdata)
  );

  // a new result word only ever comes out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q) == S_DONE)
    else $error("result word without finished item");

  // text memory is written only by the sequencer walks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_INIT || state_q == S_RTWR || state_q == S_PAD ||
                state_q == S_BLANK))
    else $error("text memory write outside a walk");

  // a text read passes through the read state to wait for the registered memory data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.func == FUNC_READ && in_i.read_target |=> state_q == S_RD)
    else $error("text read did not wait for memory data");

endmodule
